// ===== design/mcic_pkg.sv =====
`timescale 1ns / 1ps

package mcic_pkg;

  localparam int CORES            = 4;
  localparam int THREADS_PER_CORE = 2;
  localparam int NCTX             = CORES * THREADS_PER_CORE;
  localparam int MAX_RESULTS      = 8;

  localparam int STEP_W = (NCTX > 1) ? $clog2(NCTX) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_WRITE  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [31:0] LEVEL_BITS_MASK = 32'hffff_fffe;
  localparam logic [31:0] ENABLE_BIT_MASK = 32'h0000_0001;
  localparam int TIMER_BIT    = 10;
  localparam int SERIAL_BIT   = 12;
  localparam int EXTERNAL_BIT = 13;
  localparam int LEVEL_TOP    = 15;

  typedef enum logic [1:0] {
    MODE_DISABLED     = 2'd0,
    MODE_ENABLED      = 2'd1,
    MODE_INTERRUPTING = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } seq_state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  context_req;
    logic [3:0]  byte_en;
    logic [31:0] write_data;
    logic        timer_req;
    logic        serial_req;
    logic        external_req;
  } req_beat_t;

  typedef struct packed {
    logic [7:0]  out_context;
    logic [3:0]  level;
    logic        level_update;
    logic [31:0] read_data;
    logic        bad_context;
    logic        last;
  } rsp_beat_t;

  typedef struct packed {
    logic [31:0] word;
    mode_t       mode;
    logic [3:0]  level;
  } ctx_state_t;

  function automatic logic [3:0] lowest_level(input logic [31:0] v);
    logic [3:0] lvl;
    lvl = 4'd0;
    for (int i = LEVEL_TOP; i >= 1; i--) begin
      if (v[i]) begin
        lvl = 4'(i);
      end
    end
    return lvl;
  endfunction

  function automatic logic [31:0] merge_bytes(input logic [31:0] old_word,
                                              input logic [31:0] data,
                                              input logic [3:0]  mask);
    logic [31:0] m;
    for (int i = 0; i < 4; i++) begin
      m[8*i +: 8] = {8{mask[i]}};
    end
    return (old_word & ~m) | (data & m);
  endfunction

endpackage

// ===== design/multi_context_interrupt_controller.sv =====
`timescale 1ns / 1ps
// A tick, or a read or write in range, is accepted, then the context ring makes one full turn
// through the head cell, and then the final beat, if there is one, is handed over.
// A read or write to a context at or beyond NCTX skips the turn and hands over a bad-context
// beat; an unused function code is accepted and gives no beat. Each earlier tick report waits in
// a holding register for the next one. Output stalls can hold both the turn and the hand-over.
// Synchronous active-high reset clears all control words, levels and modes to disabled.
module multi_context_interrupt_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mcic_pkg::req_beat_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mcic_pkg::rsp_beat_t rsp
);
  import mcic_pkg::*;

  seq_state_t  state, state_next;
  req_beat_t   op;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  cnt;
  rsp_beat_t   pend;
  logic        pend_v;

  ctx_state_t  cell_q [NCTX];
  ctx_state_t  head_next;
  logic        rep;
  rsp_beat_t   res;
  logic        cnt_full;
  logic        out_free;
  logic        adv;
  logic        accept;
  logic        req_bad;
  logic        last_step;
  logic        rsp_load;
  rsp_beat_t   bad_beat;
  rsp_beat_t   final_beat;

  assign cnt_full  = (cnt == CNT_W'(MAX_RESULTS));
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign req_bad   = ({1'b0, req.context_req} >= 9'(NCTX));
  assign last_step = (step == STEP_W'(NCTX - 1));
  assign rsp_load  = (state == ST_SCAN && adv && rep && pend_v) ||
                     (state == ST_FLUSH && pend_v && out_free);

  always_comb begin
    bad_beat = '0;
    bad_beat.out_context = req.context_req;
    bad_beat.bad_context = 1'b1;
    final_beat = pend;
    final_beat.last = 1'b1;
  end

  mcic_head u_head (
    .cur      (cell_q[0]),
    .op       (op),
    .ctx_id   (8'(step)),
    .cnt_full (cnt_full),
    .nxt      (head_next),
    .rep      (rep),
    .res      (res)
  );

  for (genvar i = 0; i < NCTX; i++) begin : g_ring
    if (i == NCTX - 1) begin : g_tail
      mcic_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (adv),
        .d     (head_next),
        .q     (cell_q[i])
      );
    end else begin : g_body
      mcic_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (adv),
        .d     (cell_q[i+1]),
        .q     (cell_q[i])
      );
    end
  end

  always_comb begin
    state_next = state;
    adv = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && req.func != FUNC_UNUSED) begin
          state_next = (req.func != FUNC_TICK && req_bad) ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        adv = !(rep && pend_v && !out_free);
        if (adv && last_step) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      pend_v    <= 1'b0;
      step      <= '0;
      cnt       <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op   <= req;
            step <= '0;
            cnt  <= '0;
            if (req.func != FUNC_TICK && req.func != FUNC_UNUSED && req_bad) begin
              pend   <= bad_beat;
              pend_v <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (adv) begin
            step <= last_step ? '0 : step + STEP_W'(1);
            if (rep) begin
              cnt <= cnt + CNT_W'(1);
              if (pend_v) begin
                rsp <= pend;
              end
              pend   <= res;
              pend_v <= 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (pend_v && out_free) begin
            rsp    <= final_beat;
            pend_v <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/mcic_cell.sv =====
`timescale 1ns / 1ps

module mcic_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  mcic_pkg::ctx_state_t d,
  output mcic_pkg::ctx_state_t q
);
  import mcic_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.word  <= '0;
      q.mode  <= MODE_DISABLED;
      q.level <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== design/mcic_head.sv =====
`timescale 1ns / 1ps

module mcic_head (
  input  mcic_pkg::ctx_state_t cur,
  input  mcic_pkg::req_beat_t  op,
  input  logic [7:0]           ctx_id,
  input  logic                 cnt_full,
  output mcic_pkg::ctx_state_t nxt,
  output logic                 rep,
  output mcic_pkg::rsp_beat_t  res
);
  import mcic_pkg::*;

  logic [31:0] vec;
  logic [3:0]  lvl;
  logic        hit;

  always_comb begin
    vec = '0;
    vec[TIMER_BIT]    = op.timer_req;
    vec[SERIAL_BIT]   = op.serial_req;
    vec[EXTERNAL_BIT] = op.external_req;
    lvl = lowest_level(vec & cur.word & LEVEL_BITS_MASK);
    hit = (ctx_id == op.context_req);

    nxt = cur;
    rep = 1'b0;
    res = '0;
    res.out_context = ctx_id;

    case (op.func)
      FUNC_TICK: begin
        if (cur.mode == MODE_ENABLED) begin
          nxt.level = lvl;
          if (lvl != 4'd0) begin
            nxt.mode = MODE_INTERRUPTING;
            rep = !cnt_full;
            res.level = lvl;
            res.level_update = 1'b1;
          end
        end
      end
      FUNC_READ: begin
        if (hit) begin
          rep = 1'b1;
          res.level = cur.level;
          res.read_data = cur.word;
        end
      end
      FUNC_WRITE: begin
        if (hit) begin
          rep = 1'b1;
          nxt.word = merge_bytes(cur.word, op.write_data, op.byte_en);
          if ((op.write_data & ENABLE_BIT_MASK) == '0) begin
            nxt.mode = MODE_DISABLED;
            nxt.level = 4'd0;
            res.level_update = 1'b1;
          end else if (cur.mode == MODE_DISABLED) begin
            nxt.mode = MODE_ENABLED;
            nxt.level = 4'd0;
            res.level_update = 1'b1;
          end else begin
            res.level = cur.level;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/mcic_checker.sv =====
`timescale 1ns / 1ps

module mcic_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input mcic_pkg::req_beat_t req,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input mcic_pkg::rsp_beat_t rsp
);
  import mcic_pkg::*;

  // A stalled result beat holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  // Any meaningful request keeps the input stalled in the following cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.func != FUNC_UNUSED |=> req_stall)
    else $error("request accepted while previous one in flight");

  // An out-of-range access reports alone and touches nothing.
  a_bad_ctx: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bad_context |->
      rsp.last && !rsp.level_update && rsp.read_data == 32'd0 && rsp.level == 4'd0)
    else $error("bad context beat malformed");

  // Only tick reports come in groups, and each of them drives a new level.
  a_group_is_tick: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.level_update && rsp.level != 4'd0 &&
      rsp.read_data == 32'd0)
    else $error("non-final beat is not a tick report");

endmodule

bind multi_context_interrupt_controller mcic_checker u_mcic_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
